>>> hw/rtl/tgcw_pkg.sv
// Shared types, operation codes and constants for the text grid cursor writer.
`default_nettype none

package tgcw_pkg;

    // Classified operations passed from the front end to the back end.
    localparam logic [2:0] OP_PUT_PLAIN = 3'd0;
    localparam logic [2:0] OP_PUT_ESC2  = 3'd1;
    localparam logic [2:0] OP_PUT_ESC8  = 3'd2;
    localparam logic [2:0] OP_MOVE      = 3'd3;
    localparam logic [2:0] OP_CLEAR     = 3'd4;
    localparam logic [2:0] OP_READ      = 3'd5;

    // Request types as they arrive on the input port.
    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_MOVE  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    // Configuration register indexes.
    localparam logic REG_COLUMNS = 1'b0;
    localparam logic REG_ROWS    = 1'b1;

    localparam logic [7:0] COLUMNS_RESET = 8'd80;
    localparam logic [6:0] ROWS_RESET    = 7'd25;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [31:0] CHAR_NEWLINE  = 32'd10;
    localparam logic [7:0]  CHAR_OPEN     = 8'h5B;
    localparam logic [7:0]  CHAR_ZERO     = 8'h30;
    localparam logic [7:0]  CHAR_X        = 8'h78;
    localparam logic [7:0]  CHAR_CLOSE    = 8'h5D;

    // Index of the last escape character for two and eight hex digits.
    localparam logic [3:0] ESC2_LAST = 4'd5;
    localparam logic [3:0] ESC8_LAST = 4'd11;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] code;
        logic [7:0]  col;
        logic [7:0]  row;
        logic [3:0]  style;
        logic [31:0] link;
        logic [31:0] fore;
        logic [31:0] back;
        logic        rev;
    } entry_t;

    typedef struct packed {
        logic [15:0] ch;
        logic [3:0]  style;
        logic [31:0] link;
        logic [31:0] fore;
        logic [31:0] back;
        logic        rev;
    } cell_t;

    localparam cell_t CELL_BLANK = '{
        ch: 16'h0020, style: 4'h0, link: 32'h0, fore: 32'h0, back: 32'h0, rev: 1'b0
    };

    localparam cell_t CELL_ZERO = '{
        ch: 16'h0000, style: 4'h0, link: 32'h0, fore: 32'h0, back: 32'h0, rev: 1'b0
    };

    function automatic logic [7:0] hex_char(input logic [3:0] nibble);
        logic [7:0] wide;
        wide = {4'h0, nibble};
        if (nibble < 4'd10)
        begin
            return CHAR_ZERO + wide;
        end
        return 8'h37 + wide;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tgcw_front.sv
// Front end: takes request words from the input port and classifies them.
`default_nettype none

module tgcw_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 init_busy,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [1:0]           req_type,
    input  wire logic [31:0]          char_code,
    input  wire logic [7:0]           col,
    input  wire logic [7:0]           row,
    input  wire logic [3:0]           style_id,
    input  wire logic [31:0]          link_id,
    input  wire logic [31:0]          fore_colour,
    input  wire logic [31:0]          back_colour,
    input  wire logic                 reverse_video,
    output logic                      push_valid,
    input  wire logic                 push_ready,
    output tgcw_pkg::entry_t          push_entry
);

    logic             valid_reg;
    logic             valid_next;
    tgcw_pkg::entry_t entry_reg;
    tgcw_pkg::entry_t entry_next;
    tgcw_pkg::entry_t classified;
    logic             accept;

    always_comb
    begin
        classified.code  = char_code;
        classified.col   = col;
        classified.row   = row;
        classified.style = style_id;
        classified.link  = link_id;
        classified.fore  = fore_colour;
        classified.back  = back_colour;
        classified.rev   = reverse_video;
        case (req_type)
            tgcw_pkg::REQ_PUT:
            begin
                // Printable codes and newline go straight through; the rest become escapes.
                if (char_code inside {tgcw_pkg::CHAR_NEWLINE, [32'd32:32'd126],
                                      [32'd160:32'hFFFF]})
                begin
                    classified.op = tgcw_pkg::OP_PUT_PLAIN;
                end
                else if (char_code <= 32'hFF)
                begin
                    classified.op = tgcw_pkg::OP_PUT_ESC2;
                end
                else
                begin
                    classified.op = tgcw_pkg::OP_PUT_ESC8;
                end
            end
            tgcw_pkg::REQ_MOVE:  classified.op = tgcw_pkg::OP_MOVE;
            tgcw_pkg::REQ_CLEAR: classified.op = tgcw_pkg::OP_CLEAR;
            default:             classified.op = tgcw_pkg::OP_READ;
        endcase
    end

    assign in_stall   = init_busy || (valid_reg && !push_ready);
    assign accept     = in_valid && !in_stall;
    assign push_valid = valid_reg;
    assign push_entry = entry_reg;

    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (accept)
        begin
            valid_next = 1'b1;
            entry_next = classified;
        end
        else if (push_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

>>> hw/rtl/tgcw_queue.sv
// Short queue of classified request words between the front and back ends.
`default_nettype none

module tgcw_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire tgcw_pkg::entry_t  push_entry,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output tgcw_pkg::entry_t       pop_entry
);

    localparam int PTR_W = (tgcw_pkg::QUEUE_DEPTH > 1) ? $clog2(tgcw_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(tgcw_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(tgcw_pkg::QUEUE_DEPTH - 1);

    tgcw_pkg::entry_t slots_reg [tgcw_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(tgcw_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/tgcw_back.sv
// Back end: cursor, cell memory, escape sequencing, clear sweep and result register.
`default_nettype none

module tgcw_back #(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [7:0]        grid_columns,
    input  wire logic [6:0]        grid_rows,
    input  wire logic              pop_valid,
    output logic                   pop_ready,
    input  wire tgcw_pkg::entry_t  pop_entry,
    output logic                   init_busy,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [15:0]            cell_char,
    output logic [3:0]             cell_style,
    output logic [31:0]            cell_link,
    output logic [31:0]            cell_fore,
    output logic [31:0]            cell_back,
    output logic                   cell_reverse,
    output logic [7:0]             cursor_col,
    output logic [7:0]             cursor_row,
    output logic [3:0]             cells_written
);

    localparam int CELLS  = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
    localparam logic [8:0] COLS_LIMIT = 9'(MAX_COLS);
    localparam logic [8:0] ROWS_LIMIT = 9'(MAX_ROWS);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_PUT    = 3'd2;
    localparam logic [2:0] ST_READ   = 3'd3;
    localparam logic [2:0] ST_RESULT = 3'd4;

    tgcw_pkg::cell_t mem [CELLS];

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [7:0]        x_reg;
    logic [7:0]        x_next;
    logic [7:0]        y_reg;
    logic [7:0]        y_next;
    tgcw_pkg::entry_t  cmd_reg;
    tgcw_pkg::entry_t  cmd_next;
    logic [3:0]        step_reg;
    logic [3:0]        step_next;
    logic [3:0]        written_reg;
    logic [3:0]        written_next;
    logic              hit_reg;
    logic              hit_next;
    logic              init_reg;
    logic              init_next;
    logic [ADDR_W-1:0] sweep_reg;
    logic [ADDR_W-1:0] sweep_next;
    tgcw_pkg::cell_t   rd_data_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    tgcw_pkg::cell_t   out_cell_reg;
    logic [7:0]        out_col_reg;
    logic [7:0]        out_row_reg;
    logic [3:0]        out_written_reg;

    logic [8:0]        cols_eff;
    logic [8:0]        rows_eff;
    logic              cursor_in_grid;
    logic              read_in_grid;
    logic [3:0]        last_step;
    logic [2:0]        nib_idx;
    logic [4:0]        nib_shift;
    logic [3:0]        nibble;
    logic [7:0]        esc_char;
    logic [15:0]       put_char;
    logic              is_newline;
    logic [7:0]        x_inc;
    logic              out_free;
    logic              out_load;
    logic              mem_we;
    logic [ADDR_W-1:0] wr_addr;
    tgcw_pkg::cell_t   wr_data;
    logic              mem_re;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] cursor_addr;
    logic [ADDR_W-1:0] cmd_addr;

    // Register values out of range are clamped, the raw value stays in the register.
    always_comb
    begin
        if (grid_columns == 8'd0)
        begin
            cols_eff = 9'd1;
        end
        else if ({1'b0, grid_columns} > COLS_LIMIT)
        begin
            cols_eff = COLS_LIMIT;
        end
        else
        begin
            cols_eff = {1'b0, grid_columns};
        end
        if (grid_rows == 7'd0)
        begin
            rows_eff = 9'd1;
        end
        else if ({2'b00, grid_rows} > ROWS_LIMIT)
        begin
            rows_eff = ROWS_LIMIT;
        end
        else
        begin
            rows_eff = {2'b00, grid_rows};
        end
    end

    assign cursor_in_grid = ({1'b0, y_reg} < rows_eff) && ({1'b0, x_reg} < cols_eff);
    assign read_in_grid   = ({1'b0, cmd_reg.row} < rows_eff) && ({1'b0, cmd_reg.col} < cols_eff);
    assign cursor_addr    = ADDR_W'(ADDR_W'(y_reg) * ADDR_W'(MAX_COLS)) + ADDR_W'(x_reg);
    assign cmd_addr       = ADDR_W'(ADDR_W'(cmd_reg.row) * ADDR_W'(MAX_COLS))
                          + ADDR_W'(cmd_reg.col);

    // Escape sequencing: bracket, "0x", hex digits with the most significant first, bracket.
    always_comb
    begin
        case (cmd_reg.op)
            tgcw_pkg::OP_PUT_ESC2: last_step = tgcw_pkg::ESC2_LAST;
            tgcw_pkg::OP_PUT_ESC8: last_step = tgcw_pkg::ESC8_LAST;
            default:               last_step = 4'd0;
        endcase
        nib_idx   = 3'((cmd_reg.op == tgcw_pkg::OP_PUT_ESC8 ? 4'd10 : 4'd4) - step_reg);
        nib_shift = {nib_idx, 2'b00};
        nibble    = 4'(cmd_reg.code >> nib_shift);
        case (step_reg)
            4'd0:    esc_char = tgcw_pkg::CHAR_OPEN;
            4'd1:    esc_char = tgcw_pkg::CHAR_ZERO;
            4'd2:    esc_char = tgcw_pkg::CHAR_X;
            default: esc_char = (step_reg == last_step) ? tgcw_pkg::CHAR_CLOSE
                                                        : tgcw_pkg::hex_char(nibble);
        endcase
        if (cmd_reg.op == tgcw_pkg::OP_PUT_PLAIN)
        begin
            put_char = cmd_reg.code[15:0];
        end
        else
        begin
            put_char = {8'h00, esc_char};
        end
        is_newline = (cmd_reg.op == tgcw_pkg::OP_PUT_PLAIN)
                  && (cmd_reg.code == tgcw_pkg::CHAR_NEWLINE);
    end

    assign x_inc    = x_reg + 8'd1;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next   = state_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        cmd_next     = cmd_reg;
        step_next    = step_reg;
        written_next = written_reg;
        hit_next     = hit_reg;
        init_next    = init_reg;
        sweep_next   = sweep_reg;
        pop_ready    = 1'b0;
        out_load     = 1'b0;
        mem_we       = 1'b0;
        wr_addr      = cursor_addr;
        wr_data      = '{ch: put_char, style: cmd_reg.style, link: cmd_reg.link,
                         fore: cmd_reg.fore, back: cmd_reg.back, rev: cmd_reg.rev};
        mem_re       = 1'b0;
        rd_addr      = cmd_addr;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we     = 1'b1;
                wr_addr    = sweep_reg;
                wr_data    = tgcw_pkg::CELL_BLANK;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == LAST_ADDR)
                begin
                    sweep_next = '0;
                    if (init_reg)
                    begin
                        init_next  = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    pop_ready    = 1'b1;
                    cmd_next     = pop_entry;
                    step_next    = 4'd0;
                    written_next = 4'd0;
                    hit_next     = 1'b0;
                    case (pop_entry.op)
                        tgcw_pkg::OP_PUT_PLAIN,
                        tgcw_pkg::OP_PUT_ESC2,
                        tgcw_pkg::OP_PUT_ESC8:
                        begin
                            state_next = ST_PUT;
                        end
                        tgcw_pkg::OP_MOVE:
                        begin
                            x_next     = pop_entry.col;
                            y_next     = pop_entry.row;
                            state_next = ST_RESULT;
                        end
                        tgcw_pkg::OP_CLEAR:
                        begin
                            x_next     = 8'd0;
                            y_next     = 8'd0;
                            sweep_next = '0;
                            state_next = ST_CLEAR;
                        end
                        tgcw_pkg::OP_READ:
                        begin
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_PUT:
            begin
                // A character is dropped, cursor unchanged, while the cursor lies outside the grid.
                if (cursor_in_grid)
                begin
                    if (is_newline)
                    begin
                        x_next = 8'd0;
                        y_next = y_reg + 8'd1;
                    end
                    else
                    begin
                        mem_we       = 1'b1;
                        written_next = written_reg + 4'd1;
                        if ({1'b0, x_inc} >= cols_eff)
                        begin
                            x_next = 8'd0;
                            y_next = y_reg + 8'd1;
                        end
                        else
                        begin
                            x_next = x_inc;
                        end
                    end
                end
                step_next = step_reg + 4'd1;
                if (step_reg == last_step)
                begin
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_READ:
            begin
                mem_re     = read_in_grid;
                hit_next   = read_in_grid;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            x_reg         <= 8'd0;
            y_reg         <= 8'd0;
            step_reg      <= 4'd0;
            written_reg   <= 4'd0;
            hit_reg       <= 1'b0;
            init_reg      <= 1'b1;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            step_reg      <= step_next;
            written_reg   <= written_next;
            hit_reg       <= hit_next;
            init_reg      <= init_next;
            sweep_reg     <= sweep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        if (out_load)
        begin
            out_cell_reg    <= hit_reg ? rd_data_reg : tgcw_pkg::CELL_ZERO;
            out_col_reg     <= x_next;
            out_row_reg     <= y_next;
            out_written_reg <= written_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign init_busy     = init_reg;
    assign out_valid     = out_valid_reg;
    assign cell_char     = out_cell_reg.ch;
    assign cell_style    = out_cell_reg.style;
    assign cell_link     = out_cell_reg.link;
    assign cell_fore     = out_cell_reg.fore;
    assign cell_back     = out_cell_reg.back;
    assign cell_reverse  = out_cell_reg.rev;
    assign cursor_col    = out_col_reg;
    assign cursor_row    = out_row_reg;
    assign cells_written = out_written_reg;

endmodule

`default_nettype wire

>>> hw/rtl/text_grid_cursor_writer.sv
// Top level of the text grid cursor writer: configuration registers and the three parts.
`default_nettype none

// A character-cell grid of up to MAX_COLS by MAX_ROWS cells with a write cursor. Requests are
// put character, move cursor, clear grid and read cell, and each gives one result word with
// the cursor after the request. A request that follows others waits only for the back end,
// where an escape is written one character at a time, since the single write port of the
// cell memory stores one cell a cycle. A clear walks every stored cell. After reset the same
// sweep initialises the memory, during which no request word is taken; configuration writes
// are taken at any time and are meant to be made while the block is idle.
module text_grid_cursor_writer #(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  req_type,
    input  wire logic [31:0] char_code,
    input  wire logic [7:0]  col,
    input  wire logic [7:0]  row,
    input  wire logic [3:0]  style_id,
    input  wire logic [31:0] link_id,
    input  wire logic [31:0] fore_colour,
    input  wire logic [31:0] back_colour,
    input  wire logic        reverse_video,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      cell_char,
    output logic [3:0]       cell_style,
    output logic [31:0]      cell_link,
    output logic [31:0]      cell_fore,
    output logic [31:0]      cell_back,
    output logic             cell_reverse,
    output logic [7:0]       cursor_col,
    output logic [7:0]       cursor_row,
    output logic [3:0]       cells_written
);

    logic [7:0]       columns_reg;
    logic [7:0]       columns_next;
    logic [6:0]       rows_reg;
    logic [6:0]       rows_next;
    logic             init_busy;
    logic             push_valid;
    logic             push_ready;
    tgcw_pkg::entry_t push_entry;
    logic             pop_valid;
    logic             pop_ready;
    tgcw_pkg::entry_t pop_entry;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        columns_next = columns_reg;
        rows_next    = rows_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tgcw_pkg::REG_COLUMNS: columns_next = cfg_data;
                tgcw_pkg::REG_ROWS:    rows_next    = cfg_data[6:0];
                default:               columns_next = columns_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= tgcw_pkg::COLUMNS_RESET;
            rows_reg    <= tgcw_pkg::ROWS_RESET;
        end
        else
        begin
            columns_reg <= columns_next;
            rows_reg    <= rows_next;
        end
    end

    tgcw_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .init_busy     (init_busy),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .char_code     (char_code),
        .col           (col),
        .row           (row),
        .style_id      (style_id),
        .link_id       (link_id),
        .fore_colour   (fore_colour),
        .back_colour   (back_colour),
        .reverse_video (reverse_video),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_entry    (push_entry)
    );

    tgcw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    tgcw_back #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .grid_columns  (columns_reg),
        .grid_rows     (rows_reg),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_entry     (pop_entry),
        .init_busy     (init_busy),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cell_char     (cell_char),
        .cell_style    (cell_style),
        .cell_link     (cell_link),
        .cell_fore     (cell_fore),
        .cell_back     (cell_back),
        .cell_reverse  (cell_reverse),
        .cursor_col    (cursor_col),
        .cursor_row    (cursor_row),
        .cells_written (cells_written)
    );

`ifndef SYNTHESIS
    // No request word may enter while the memory is still being initialised.
    assert property (@(posedge clk) disable iff (!rst_n) init_busy |-> in_stall)
        else $error("request taken during the initialising sweep");

    // The initialising sweep never produces a result word.
    assert property (@(posedge clk) disable iff (!rst_n) init_busy |-> !out_valid)
        else $error("result word shown during the initialising sweep");

    // An escape writes at most twelve cells.
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> (cells_written <= 4'd12))
        else $error("cell count of a result word out of range");
`endif

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the text grid cursor writer with its own grid and cursor model.
`timescale 1ns / 1ps

module tb;

    localparam int GRID_MAX_COLS = 128;
    localparam int GRID_MAX_ROWS = 64;
    localparam int CELL_COUNT    = GRID_MAX_COLS * GRID_MAX_ROWS;
    localparam int MAX_REPORTS   = 10;
    localparam int STALL_LIMIT   = 40000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int PHASES        = 11;
    localparam int PHASE_ITEMS   = 127;
    localparam int QUIET_PHASE   = 5;

    localparam logic [31:0] ASCII_LOW  = 32'd32;
    localparam logic [31:0] ASCII_HIGH = 32'd126;
    localparam logic [31:0] WIDE_LOW   = 32'd160;
    localparam logic [31:0] WIDE_HIGH  = 32'hFFFF;
    localparam logic [31:0] SHORT_MAX  = 32'hFF;
    localparam logic [7:0]  LETTER_A   = 8'h41;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] code;
        logic [7:0]  col;
        logic [7:0]  row;
        logic [3:0]  style;
        logic [31:0] link;
        logic [31:0] fore;
        logic [31:0] back;
        logic        rev;
    } grid_req_t;

    typedef struct {
        tgcw_pkg::cell_t data;
        logic [7:0]      cur_col;
        logic [7:0]      cur_row;
        logic [3:0]      written;
    } grid_result_t;

    class grid_scoreboard;
        tgcw_pkg::cell_t cells [CELL_COUNT];
        logic [7:0]      columns_reg;
        logic [6:0]      rows_reg;
        logic [7:0]      cur_x;
        logic [7:0]      cur_y;
        grid_result_t    expected_q [$];
        int              faults;
        int              checked;
        int              requests;
        int              escapes;
        int              reads;
        int              clears;

        function new();
            columns_reg = tgcw_pkg::COLUMNS_RESET;
            rows_reg    = tgcw_pkg::ROWS_RESET;
            cur_x       = 8'd0;
            cur_y       = 8'd0;
            blank_all();
        endfunction

        function void blank_all();
            foreach (cells[i])
            begin
                cells[i] = tgcw_pkg::CELL_BLANK;
            end
        endfunction

        function int cols_used();
            if (columns_reg == 0)
            begin
                return 1;
            end
            if (columns_reg > GRID_MAX_COLS)
            begin
                return GRID_MAX_COLS;
            end
            return int'(columns_reg);
        endfunction

        function int rows_used();
            if (rows_reg == 0)
            begin
                return 1;
            end
            if (rows_reg > GRID_MAX_ROWS)
            begin
                return GRID_MAX_ROWS;
            end
            return int'(rows_reg);
        endfunction

        function bit cursor_inside();
            return (int'(cur_y) < rows_used()) && (int'(cur_x) < cols_used());
        endfunction

        function void write_reg(logic idx, logic [7:0] value);
            if (idx == tgcw_pkg::REG_COLUMNS)
            begin
                columns_reg = value;
            end
            else
            begin
                rows_reg = value[6:0];
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // One character at the cursor; the cursor wraps to the next row past the last column.
        function int store_char(logic [31:0] c, grid_req_t r);
            int idx;
            if (!cursor_inside())
            begin
                return 0;
            end
            if (c == tgcw_pkg::CHAR_NEWLINE)
            begin
                cur_x = 8'd0;
                cur_y = cur_y + 8'd1;
                return 0;
            end
            idx = int'(cur_y) * GRID_MAX_COLS + int'(cur_x);
            cells[idx] = '{ch: c[15:0], style: r.style, link: r.link, fore: r.fore,
                           back: r.back, rev: r.rev};
            cur_x = cur_x + 8'd1;
            if (int'(cur_x) >= cols_used())
            begin
                cur_x = 8'd0;
                cur_y = cur_y + 8'd1;
            end
            return 1;
        endfunction

        // Unprintable codes become a bracketed hex escape, each character placed in turn.
        function int put_code(logic [31:0] c, grid_req_t r);
            logic [7:0] esc [12];
            logic [3:0] nib;
            int         digits;
            int         i;
            int         total;
            if (!cursor_inside())
            begin
                return 0;
            end
            if (c == tgcw_pkg::CHAR_NEWLINE || (c >= ASCII_LOW && c <= ASCII_HIGH) ||
                (c >= WIDE_LOW && c <= WIDE_HIGH))
            begin
                return store_char(c, r);
            end
            escapes++;
            digits = (c <= SHORT_MAX) ? 2 : 8;
            esc[0] = tgcw_pkg::CHAR_OPEN;
            esc[1] = tgcw_pkg::CHAR_ZERO;
            esc[2] = tgcw_pkg::CHAR_X;
            for (i = 0; i < digits; i++)
            begin
                nib = c[4 * (digits - 1 - i) +: 4];
                esc[3 + i] = (nib < 4'd10) ? tgcw_pkg::CHAR_ZERO + {4'h0, nib}
                                           : LETTER_A + {4'h0, nib} - 8'd10;
            end
            esc[3 + digits] = tgcw_pkg::CHAR_CLOSE;
            total = 0;
            for (i = 0; i < digits + 4; i++)
            begin
                total += store_char({24'h0, esc[i]}, r);
            end
            return total;
        endfunction

        function void note_request(grid_req_t r);
            grid_result_t e;
            e.data    = tgcw_pkg::CELL_ZERO;
            e.written = 4'd0;
            requests++;
            case (r.kind)
                tgcw_pkg::REQ_PUT:
                begin
                    e.written = 4'(put_code(r.code, r));
                end
                tgcw_pkg::REQ_MOVE:
                begin
                    cur_x = r.col;
                    cur_y = r.row;
                end
                tgcw_pkg::REQ_CLEAR:
                begin
                    cur_x = 8'd0;
                    cur_y = 8'd0;
                    blank_all();
                    clears++;
                end
                default:
                begin
                    reads++;
                    if (int'(r.row) < rows_used() && int'(r.col) < cols_used())
                    begin
                        e.data = cells[int'(r.row) * GRID_MAX_COLS + int'(r.col)];
                    end
                end
            endcase
            e.cur_col = cur_x;
            e.cur_row = cur_y;
            expected_q.push_back(e);
        endfunction

        function void check_result(grid_result_t got);
            grid_result_t e;
            string        diffs;
            if (expected_q.size() == 0)
            begin
                faults++;
                if (faults <= MAX_REPORTS)
                begin
                    $display("ERROR: result word with nothing expected, cursor %0d,%0d",
                             got.cur_col, got.cur_row);
                end
                return;
            end
            e = expected_q.pop_front();
            checked++;
            diffs = "";
            if (got.data.ch !== e.data.ch)
                diffs = {diffs, $sformatf(" char %h/%h", e.data.ch, got.data.ch)};
            if (got.data.style !== e.data.style)
                diffs = {diffs, $sformatf(" style %h/%h", e.data.style, got.data.style)};
            if (got.data.link !== e.data.link)
                diffs = {diffs, $sformatf(" link %h/%h", e.data.link, got.data.link)};
            if (got.data.fore !== e.data.fore)
                diffs = {diffs, $sformatf(" fore %h/%h", e.data.fore, got.data.fore)};
            if (got.data.back !== e.data.back)
                diffs = {diffs, $sformatf(" back %h/%h", e.data.back, got.data.back)};
            if (got.data.rev !== e.data.rev)
                diffs = {diffs, $sformatf(" reverse %b/%b", e.data.rev, got.data.rev)};
            if (got.cur_col !== e.cur_col)
                diffs = {diffs, $sformatf(" cursor_col %0d/%0d", e.cur_col, got.cur_col)};
            if (got.cur_row !== e.cur_row)
                diffs = {diffs, $sformatf(" cursor_row %0d/%0d", e.cur_row, got.cur_row)};
            if (got.written !== e.written)
                diffs = {diffs, $sformatf(" cells_written %0d/%0d", e.written, got.written)};
            if (diffs != "")
            begin
                faults++;
                if (faults <= MAX_REPORTS)
                begin
                    $display("ERROR: result %0d (expected/actual):%s", checked, diffs);
                end
            end
        endfunction
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic        cfg_index     = 1'b0;
    logic [7:0]  cfg_data      = 8'd0;
    logic        in_valid      = 1'b0;
    logic        in_stall;
    logic [1:0]  req_type      = tgcw_pkg::REQ_PUT;
    logic [31:0] char_code     = 32'd0;
    logic [7:0]  col           = 8'd0;
    logic [7:0]  row           = 8'd0;
    logic [3:0]  style_id      = 4'd0;
    logic [31:0] link_id       = 32'd0;
    logic [31:0] fore_colour   = 32'd0;
    logic [31:0] back_colour   = 32'd0;
    logic        reverse_video = 1'b0;
    logic        out_valid;
    logic        out_stall     = 1'b0;
    logic [15:0] cell_char;
    logic [3:0]  cell_style;
    logic [31:0] cell_link;
    logic [31:0] cell_fore;
    logic [31:0] cell_back;
    logic        cell_reverse;
    logic [7:0]  cursor_col;
    logic [7:0]  cursor_row;
    logic [3:0]  cells_written;

    logic        quiet_stretch = 1'b0;
    int          idle_cycles   = 0;

    grid_scoreboard sb = new();

    int phase_cols [PHASES] = '{128, 255, 0, 1, 5, 16, 40, 3, 128, 7, 80};
    int phase_rows [PHASES] = '{64, 127, 0, 1, 3, 8, 12, 64, 1, 100, 25};

    text_grid_cursor_writer #(
        .MAX_COLS(GRID_MAX_COLS),
        .MAX_ROWS(GRID_MAX_ROWS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .req_type(req_type),
        .char_code(char_code),
        .col(col),
        .row(row),
        .style_id(style_id),
        .link_id(link_id),
        .fore_colour(fore_colour),
        .back_colour(back_colour),
        .reverse_video(reverse_video),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .cell_char(cell_char),
        .cell_style(cell_style),
        .cell_link(cell_link),
        .cell_fore(cell_fore),
        .cell_back(cell_back),
        .cell_reverse(cell_reverse),
        .cursor_col(cursor_col),
        .cursor_row(cursor_row),
        .cells_written(cells_written)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic grid_req_t plain_request(logic [1:0] kind, logic [31:0] code,
                                                logic [7:0] c, logic [7:0] r);
        grid_req_t q;
        q.kind  = kind;
        q.code  = code;
        q.col   = c;
        q.row   = r;
        q.style = 4'($urandom_range(15));
        q.link  = ($urandom_range(3) == 0) ? 32'd0 : $urandom;
        q.fore  = $urandom;
        q.back  = $urandom;
        q.rev   = 1'($urandom_range(1));
        return q;
    endfunction

    // Mostly puts of mixed codes, with moves and reads aimed mostly inside the grid in use.
    function automatic grid_req_t random_request(int cols, int rows, logic [7:0] cx,
                                                 logic [7:0] cy);
        grid_req_t q;
        int        pick;
        q = plain_request(tgcw_pkg::REQ_PUT, $urandom, 8'($urandom_range(255)),
                          8'($urandom_range(255)));
        pick = $urandom_range(999);
        if (pick < 600)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3: q.code = $urandom_range(ASCII_HIGH, ASCII_LOW);
                4:          q.code = $urandom_range(WIDE_HIGH, WIDE_LOW);
                5:          q.code = tgcw_pkg::CHAR_NEWLINE;
                6:          q.code = $urandom_range(1) ? $urandom_range(31, 0)
                                                       : $urandom_range(159, 127);
                7:          q.code = $urandom_range(SHORT_MAX, 0);
                8:          q.code = $urandom;
                default:
                begin
                    case ($urandom_range(5))
                        0:       q.code = 32'd0;
                        1:       q.code = 32'h100;
                        2:       q.code = 32'h10000;
                        3:       q.code = 32'hFFFFFFFF;
                        4:       q.code = WIDE_LOW - 32'd1;
                        default: q.code = ASCII_HIGH + 32'd1;
                    endcase
                end
            endcase
        end
        else if (pick < 750)
        begin
            q.kind = tgcw_pkg::REQ_MOVE;
            if ($urandom_range(9) != 0)
            begin
                q.col = 8'($urandom_range(cols - 1));
                q.row = 8'($urandom_range(rows - 1));
            end
        end
        else if (pick < 995)
        begin
            q.kind = tgcw_pkg::REQ_READ;
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5, 6, 7:
                begin
                    // The cell just behind the cursor, most likely the one last written.
                    q.col = (cx == 8'd0) ? 8'd0 : cx - 8'd1;
                    q.row = cy;
                end
                17, 18, 19:
                begin
                end
                default:
                begin
                    q.col = 8'($urandom_range(cols - 1));
                    q.row = 8'($urandom_range(rows - 1));
                end
            endcase
        end
        else
        begin
            q.kind = tgcw_pkg::REQ_CLEAR;
        end
        return q;
    endfunction

    task automatic send_request(input grid_req_t q);
        while (!quiet_stretch && $urandom_range(99) < 12)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        req_type      <= q.kind;
        char_code     <= q.code;
        col           <= q.col;
        row           <= q.row;
        style_id      <= q.style;
        link_id       <= q.link;
        fore_colour   <= q.fore;
        back_colour   <= q.back;
        reverse_video <= q.rev;
        do @(posedge clk); while (in_stall);
        sb.note_request(q);
    endtask

    task automatic send_simple(input logic [1:0] kind, input logic [31:0] code,
                               input logic [7:0] c, input logic [7:0] r);
        send_request(plain_request(kind, code, c, r));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Both registers are written back to back with valid held high across the two words.
    task automatic configure(input logic [7:0] cols, input logic [7:0] rows);
        cfg_valid <= 1'b1;
        cfg_index <= tgcw_pkg::REG_COLUMNS;
        cfg_data  <= cols;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(tgcw_pkg::REG_COLUMNS, cols);
        cfg_index <= tgcw_pkg::REG_ROWS;
        cfg_data  <= rows;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(tgcw_pkg::REG_ROWS, rows);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        grid_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.data.ch    = cell_char;
            got.data.style = cell_style;
            got.data.link  = cell_link;
            got.data.fore  = cell_fore;
            got.data.back  = cell_back;
            got.data.rev   = cell_reverse;
            got.cur_col    = cursor_col;
            got.cur_row    = cursor_row;
            got.written    = cells_written;
            sb.check_result(got);
        end
        out_stall <= rst_n && !quiet_stretch && ($urandom_range(99) < 12);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles + 1 >= STALL_LIMIT)
            begin
                $display("ERROR: no handshake for %0d cycles, %0d results outstanding",
                         STALL_LIMIT, sb.pending());
                $display("status: fail");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        grid_req_t q;
        int        p;
        int        k;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset grid size of 80 by 25.
        send_simple(tgcw_pkg::REQ_READ, 32'd0, 8'd0, 8'd0);
        q = plain_request(tgcw_pkg::REQ_PUT, 32'd65, 8'd0, 8'd0);
        q.style = '1;
        q.link  = '1;
        q.fore  = '1;
        q.back  = '1;
        q.rev   = 1'b1;
        send_request(q);
        send_simple(tgcw_pkg::REQ_READ, 32'd0, 8'd0, 8'd0);
        q = plain_request(tgcw_pkg::REQ_PUT, WIDE_HIGH, 8'd0, 8'd0);
        q.style = '0;
        q.link  = '0;
        q.fore  = '0;
        q.back  = '0;
        q.rev   = 1'b0;
        send_request(q);
        send_simple(tgcw_pkg::REQ_PUT, ASCII_LOW, 8'd0, 8'd0);
        send_simple(tgcw_pkg::REQ_PUT, ASCII_HIGH, 8'd0, 8'd0);
        send_simple(tgcw_pkg::REQ_PUT, WIDE_LOW, 8'd0, 8'd0);
        send_simple(tgcw_pkg::REQ_PUT, ASCII_HIGH + 32'd1, 8'd0, 8'd0);
        send_simple(tgcw_pkg::REQ_PUT, WIDE_LOW - 32'd1, 8'd0, 8'd0);
        send_simple(tgcw_pkg::REQ_PUT, 32'd0, 8'd0, 8'd0);
        send_simple(tgcw_pkg::REQ_PUT, 32'h10000, 8'd0, 8'd0);
        send_simple(tgcw_pkg::REQ_PUT, 32'hFFFFFFFF, 8'd0, 8'd0);
        send_simple(tgcw_pkg::REQ_PUT, tgcw_pkg::CHAR_NEWLINE, 8'd0, 8'd0);
        send_simple(tgcw_pkg::REQ_READ, 32'd0, 8'd2, 8'd0);
        send_simple(tgcw_pkg::REQ_READ, 32'd0, 8'd79, 8'd24);
        send_simple(tgcw_pkg::REQ_READ, 32'd0, 8'd80, 8'd0);
        send_simple(tgcw_pkg::REQ_READ, 32'd0, 8'd255, 8'd255);
        // A put with the cursor outside the grid is dropped.
        send_simple(tgcw_pkg::REQ_MOVE, 32'd0, 8'd255, 8'd255);
        send_simple(tgcw_pkg::REQ_PUT, 32'hFFFFFFFF, 8'd0, 8'd0);
        // An escape that runs off the bottom row writes only its first characters.
        send_simple(tgcw_pkg::REQ_MOVE, 32'd0, 8'd78, 8'd24);
        send_simple(tgcw_pkg::REQ_PUT, 32'h100, 8'd0, 8'd0);
        send_simple(tgcw_pkg::REQ_READ, 32'd0, 8'd79, 8'd24);
        send_simple(tgcw_pkg::REQ_CLEAR, 32'd0, 8'd0, 8'd0);
        send_simple(tgcw_pkg::REQ_READ, 32'd0, 8'd79, 8'd24);
        wait_drained();

        for (p = 0; p < PHASES; p++)
        begin
            configure(8'(phase_cols[p]), 8'(phase_rows[p]));
            quiet_stretch <= (p == QUIET_PHASE);
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                send_request(random_request(sb.cols_used(), sb.rows_used(), sb.cur_x, sb.cur_y));
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.faults += sb.pending();
        $display("Checked %0d result words from %0d requests over %0d grid sizes.",
                 sb.checked, sb.requests, PHASES + 1);
        $display("Requests included %0d escapes, %0d reads and %0d clears; %0d faults.",
                 sb.escapes, sb.reads, sb.clears, sb.faults);
        if (sb.faults == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/tgcw_pkg.sv
hw/rtl/tgcw_front.sv
hw/rtl/tgcw_queue.sv
hw/rtl/tgcw_back.sv
hw/rtl/text_grid_cursor_writer.sv
tb/tb.sv
